[rtl/bqf_pkg.sv]
package bqf_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 24;
   localparam int STATE_W   = SAMPLE_W + COEF_W;
   localparam int FRAC_W    = COEF_W - 2;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W    = 4;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [STATE_W-1:0]  state_type;
   typedef logic [STEP_W-1:0]          step_type;

   localparam coef_type  COEF_ONE   = {2'b01, {FRAC_W{1'b0}}};
   localparam state_type STATE_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
   localparam state_type STATE_MIN  = {1'b1, {(STATE_W-1){1'b0}}};
   localparam state_type ROUND_HALF = {{(STATE_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Register index of each coefficient on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_sel_type;

   typedef enum logic [1:0] {
      COND_ALWAYS = 2'd0,
      COND_REQ    = 2'd1,
      COND_OUT    = 2'd2
   } cond_type;

   typedef enum logic {
      MUL_A_X = 1'b0,
      MUL_A_Y = 1'b1
   } mul_a_type;

   typedef enum logic {
      ADD_A_ACC  = 1'b0,
      ADD_A_PROD = 1'b1
   } add_a_type;

   typedef enum logic [2:0] {
      ADD_B_ZERO     = 3'd0,
      ADD_B_PROD     = 3'd1,
      ADD_B_NEG_PROD = 3'd2,
      ADD_B_Z1       = 3'd3,
      ADD_B_Z2       = 3'd4,
      ADD_B_HALF     = 3'd5
   } add_b_type;

   typedef struct packed {
      cond_type     cond;
      logic         jump;
      step_type     target;
      logic         x_load;
      logic         mul_en;
      mul_a_type    mul_a;
      coef_sel_type mul_b;
      logic         acc_en;
      add_a_type    add_a;
      add_b_type    add_b;
      logic         y_load;
      logic         z1_wr;
      logic         z2_wr;
      logic         push;
   } ctrl_word_type;

   typedef struct packed {
      ctrl_word_type word;
      logic          fire;
   } seq_ctrl_type;

   // Program steps.
   localparam step_type S_WAIT     = 4'd0;
   localparam step_type S_MUL_B0   = 4'd1;
   localparam step_type S_ADD_Z1   = 4'd2;
   localparam step_type S_ADD_HALF = 4'd3;
   localparam step_type S_ROUND    = 4'd4;
   localparam step_type S_MOVE_B1  = 4'd5;
   localparam step_type S_SUB_A1   = 4'd6;
   localparam step_type S_ADD_Z2   = 4'd7;
   localparam step_type S_MOVE_B2  = 4'd8;
   localparam step_type S_SUB_A2   = 4'd9;

   // Microcode store. Each product is written to the product register in a step
   // before the one in which the adder consumes it, so multiplies and adds overlap.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = '0;
      w.target = S_WAIT;
      unique case (step)
         S_WAIT: begin
            w.cond   = COND_REQ;
            w.x_load = 1'b1;
         end
         S_MUL_B0: begin
            w.mul_en = 1'b1;
            w.mul_a  = MUL_A_X;
            w.mul_b  = COEF_B0;
         end
         S_ADD_Z1: begin
            w.acc_en = 1'b1;
            w.add_a  = ADD_A_PROD;
            w.add_b  = ADD_B_Z1;
         end
         S_ADD_HALF: begin
            w.acc_en = 1'b1;
            w.add_a  = ADD_A_ACC;
            w.add_b  = ADD_B_HALF;
         end
         S_ROUND: begin
            w.y_load = 1'b1;
            w.mul_en = 1'b1;
            w.mul_a  = MUL_A_X;
            w.mul_b  = COEF_B1;
         end
         S_MOVE_B1: begin
            w.acc_en = 1'b1;
            w.add_a  = ADD_A_PROD;
            w.add_b  = ADD_B_ZERO;
            w.mul_en = 1'b1;
            w.mul_a  = MUL_A_Y;
            w.mul_b  = COEF_A1;
         end
         S_SUB_A1: begin
            w.acc_en = 1'b1;
            w.add_a  = ADD_A_ACC;
            w.add_b  = ADD_B_NEG_PROD;
            w.mul_en = 1'b1;
            w.mul_a  = MUL_A_X;
            w.mul_b  = COEF_B2;
         end
         S_ADD_Z2: begin
            w.acc_en = 1'b1;
            w.add_a  = ADD_A_ACC;
            w.add_b  = ADD_B_Z2;
            w.z1_wr  = 1'b1;
         end
         S_MOVE_B2: begin
            w.acc_en = 1'b1;
            w.add_a  = ADD_A_PROD;
            w.add_b  = ADD_B_ZERO;
            w.mul_en = 1'b1;
            w.mul_a  = MUL_A_Y;
            w.mul_b  = COEF_A2;
         end
         S_SUB_A2: begin
            w.cond  = COND_OUT;
            w.jump  = 1'b1;
            w.add_a = ADD_A_ACC;
            w.add_b = ADD_B_NEG_PROD;
            w.z2_wr = 1'b1;
            w.push  = 1'b1;
         end
         default: begin
            w.jump = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

[rtl/bqf_req_if.sv]
interface bqf_req_if;
   import bqf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

[rtl/bqf_rsp_if.sv]
interface bqf_rsp_if;
   import bqf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

[rtl/bqf_seq.sv]
module bqf_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_free,
   output logic                  req_ready,
   output bqf_pkg::seq_ctrl_type ctrl,
   output bqf_pkg::step_type     step
);
   import bqf_pkg::*;

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type word;
   logic          fire;

   assign word = ucode_rom(step_ff);

   always_comb begin
      unique case (word.cond)
         COND_ALWAYS: fire = 1'b1;
         COND_REQ:    fire = req_valid;
         COND_OUT:    fire = out_free;
         default:     fire = 1'b1;
      endcase
   end

   // A step whose condition is not met repeats without side effects.
   always_comb begin
      step_in = step_ff;
      if (fire) begin
         step_in = word.jump ? word.target : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign req_ready  = (word.cond == COND_REQ);
   assign ctrl.word  = word;
   assign ctrl.fire  = fire;
   assign step       = step_ff;
endmodule

[rtl/bqf_datapath.sv]
module bqf_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  bqf_pkg::seq_ctrl_type          ctrl,
   input  bqf_pkg::sample_type            sample_in,
   input  logic                           csr_wr_en,
   input  logic [bqf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  bqf_pkg::coef_type              csr_wdata,
   output bqf_pkg::sample_type            y_out
);
   import bqf_pkg::*;

   coef_type   b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   sample_type x_ff;
   sample_type y_ff;
   sample_type y_in;
   state_type  prod_ff;
   state_type  prod_in;
   state_type  acc_ff;
   state_type  z1_ff;
   state_type  z2_ff;
   sample_type mul_a_val;
   coef_type   mul_b_val;
   state_type  opa;
   state_type  opb;
   logic signed [STATE_W:0] sum_wide;
   state_type  sum_sat;
   logic [STATE_W-FRAC_W-SAMPLE_W:0] top_bits;
   logic       en;

   assign en = ctrl.fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= COEF_ONE;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            COEF_B0: b0_ff <= csr_wdata;
            COEF_B1: b1_ff <= csr_wdata;
            COEF_B2: b2_ff <= csr_wdata;
            COEF_A1: a1_ff <= csr_wdata;
            COEF_A2: a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ctrl.word.mul_a)
         MUL_A_X: mul_a_val = x_ff;
         MUL_A_Y: mul_a_val = y_ff;
         default: mul_a_val = x_ff;
      endcase
      unique case (ctrl.word.mul_b)
         COEF_B0: mul_b_val = b0_ff;
         COEF_B1: mul_b_val = b1_ff;
         COEF_B2: mul_b_val = b2_ff;
         COEF_A1: mul_b_val = a1_ff;
         COEF_A2: mul_b_val = a2_ff;
         default: mul_b_val = b0_ff;
      endcase
   end

   assign prod_in = mul_a_val * mul_b_val;

   // Saturating adder shared by every partial sum. A product never exceeds
   // 2^46 in magnitude, so its negation still fits the state width.
   always_comb begin
      unique case (ctrl.word.add_a)
         ADD_A_ACC:  opa = acc_ff;
         ADD_A_PROD: opa = prod_ff;
         default:    opa = acc_ff;
      endcase
      unique case (ctrl.word.add_b)
         ADD_B_ZERO:     opb = '0;
         ADD_B_PROD:     opb = prod_ff;
         ADD_B_NEG_PROD: opb = -prod_ff;
         ADD_B_Z1:       opb = z1_ff;
         ADD_B_Z2:       opb = z2_ff;
         ADD_B_HALF:     opb = ROUND_HALF;
         default:        opb = '0;
      endcase
      sum_wide = {opa[STATE_W-1], opa} + {opb[STATE_W-1], opb};
      if (sum_wide[STATE_W] != sum_wide[STATE_W-1]) begin
         sum_sat = sum_wide[STATE_W] ? STATE_MIN : STATE_MAX;
      end else begin
         sum_sat = sum_wide[STATE_W-1:0];
      end
   end

   // Dropping the fraction bits is the floor of the division; the output
   // clamps when the bits above the sample range are not all sign copies.
   assign top_bits = acc_ff[STATE_W-1:FRAC_W+SAMPLE_W-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         y_in = acc_ff[FRAC_W+SAMPLE_W-1:FRAC_W];
      end else begin
         y_in = acc_ff[STATE_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en && ctrl.word.x_load) begin
         x_ff <= sample_in;
      end
      if (en && ctrl.word.mul_en) begin
         prod_ff <= prod_in;
      end
      if (en && ctrl.word.acc_en) begin
         acc_ff <= sum_sat;
      end
      if (en && ctrl.word.y_load) begin
         y_ff <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z1_ff <= '0;
         z2_ff <= '0;
      end else begin
         if (en && ctrl.word.z1_wr) begin
            z1_ff <= sum_sat;
         end
         if (en && ctrl.word.z2_wr) begin
            z2_ff <= sum_sat;
         end
      end
   end

   assign y_out = y_ff;
endmodule

[rtl/biquad_filter_unit.sv]
// Second-order IIR section, transposed direct form II, run by a microcode program.
// The result is loaded into the output register in S_SUB_A2, a step that waits until that register is free.
// One sample is in flight at a time: input is taken only in S_WAIT. The single 24x24 multiplier and the
// saturating adder are shared by all five products and sums, one step per cycle unless a step waits on its condition.
// Reset: b0 = 1.0, other coefficients zero, both delay words zero, no result held.
module biquad_filter_unit (
   input  logic                          clock,
   input  logic                          reset,
   bqf_req_if.sink                       req_if,
   bqf_rsp_if.source                     rsp_if,
   input  logic                          csr_wr_en,
   input  logic [bqf_pkg::CSR_IDX_W-1:0] csr_index,
   input  bqf_pkg::coef_type             csr_wdata
);
   import bqf_pkg::*;

   seq_ctrl_type ctrl;
   step_type     step;
   sample_type   y_val;
   logic         out_free;
   logic         push;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   sample_type   rsp_sample_ff;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign push     = ctrl.fire && ctrl.word.push;

   bqf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .out_free  (out_free),
      .req_ready (req_if.ready),
      .ctrl      (ctrl),
      .step      (step)
   );

   bqf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .sample_in (req_if.sample_in),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .y_out     (y_val)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (push) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_sample_ff <= y_val;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = rsp_sample_ff;

   // A new result never overwrites one that has not been transferred.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("result register overwritten");

   // After an input transfer the sequencer is busy and takes no other input.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("input taken while busy");

   // The step counter never leaves the program.
   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      step <= S_SUB_A2)
      else $error("step counter out of program");
endmodule
